>>> sv/htld_pkg.sv
`timescale 1ns / 1ps
// Package for the Huffman tree line decoder: request codes, controller
// states, symbol constants and field widths. It depends on nothing.
package htld_pkg;

  localparam int unsigned CodeW  = 9;
  localparam int unsigned NodeW  = 8;
  localparam int unsigned SymW   = 8;
  localparam int unsigned EntryW = 2 * CodeW;

  localparam logic [CodeW-1:0] RootReset = 9'd256;
  localparam logic [SymW-1:0]  SymCr     = 8'd13;
  localparam logic [SymW-1:0]  SymLf     = 8'd10;

  typedef enum logic [1:0] {
    ReqLoad    = 2'd0,
    ReqData    = 2'd1,
    ReqRestart = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    StIdle  = 2'd0,
    StWalk  = 2'd1,
    StFlush = 2'd2
  } state_e;

endpackage

>>> sv/huffman_tree_line_decoder.sv
`timescale 1ns / 1ps
// Huffman tree line decoder: walks a node table held in a synchronous memory
// one bit per unstalled cycle. Depends on htld_pkg for codes, states and widths.
//
// The input channel (in_valid_i / in_ready_o) carries one word per request: a
// load word writes the left and right child codes of one node, a data word
// supplies one compressed byte, and a restart word returns the walk to the root
// and arms a count of leading bits to drop from the next byte. The output
// channel (out_valid_o / out_ready_i) delivers one word per decoded symbol;
// carriage returns are dropped, newline raises end_of_line_o, and last_o marks
// the final symbol produced by a data byte. The root code is written through
// cfg_we_i / cfg_wdata_i; the user must write it only while the block is idle, as
// the block does not enforce it. A data word is walked in steps: the accept cycle
// issues the first table read, each following step consumes one bit and issues
// the dependent read of the next node, and a final step releases the held symbol,
// if any, with last_o set. The single read port of the node table serialises the
// walk. Each symbol is held until the next one or the final step, so that last_o
// can be attached; the output register lets the next word be accepted while a
// result waits, and a stalled receiver pauses the walk on the step that would
// emit a second held symbol. Reset sets walk and root to node code 256.
module huffman_tree_line_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   req_type_i,
  input  logic [htld_pkg::NodeW-1:0]   node_index_i,
  input  logic [htld_pkg::CodeW-1:0]   left_child_i,
  input  logic [htld_pkg::CodeW-1:0]   right_child_i,
  input  logic [7:0]                   data_byte_i,
  input  logic [3:0]                   skip_bits_i,
  input  logic                         cfg_we_i,
  input  logic [htld_pkg::CodeW-1:0]   cfg_wdata_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [htld_pkg::SymW-1:0]    symbol_o,
  output logic                         end_of_line_o,
  output logic                         last_o
);

  // Node table: each entry holds {left child, right child}. It is not cleared
  // at reset, so every node must be loaded before a walk reaches it.
  logic [htld_pkg::EntryW-1:0] mem_q [2**htld_pkg::NodeW];
  logic [htld_pkg::EntryW-1:0] rdata_q;
  logic                        wr_en;
  logic                        rd_en;
  logic [htld_pkg::NodeW-1:0]  rd_addr;

  htld_pkg::state_e state_q, state_d;

  logic [htld_pkg::CodeW-1:0] root_q;
  logic [htld_pkg::CodeW-1:0] walk_q, walk_d;
  logic [2:0]                 skip_q, skip_d;
  logic [7:0]                 byte_q, byte_d;
  logic [2:0]                 bit_q, bit_d;

  // Symbol held back until it is known whether it is the last of its byte.
  logic                       pend_valid_q, pend_valid_d;
  logic [htld_pkg::SymW-1:0]  pend_sym_q, pend_sym_d;
  logic                       pend_eol_q, pend_eol_d;

  logic                       out_valid_q, out_valid_d;
  logic [htld_pkg::SymW-1:0]  out_sym_q, out_sym_d;
  logic                       out_eol_q, out_eol_d;
  logic                       out_last_q, out_last_d;

  logic                       accept;
  logic                       cur_bit;
  logic [htld_pkg::CodeW-1:0] child;
  logic                       is_sym;
  logic                       emit;
  logic                       out_free;
  logic                       step_ok;
  logic                       flush_ok;
  logic                       final_bit;
  logic [htld_pkg::CodeW-1:0] next_walk;

  assign accept    = in_valid_i && in_ready_o;
  assign cur_bit   = byte_q[3'(3'd7 - bit_q)];
  assign child     = cur_bit ? rdata_q[htld_pkg::EntryW-1:htld_pkg::CodeW]
                             : rdata_q[htld_pkg::CodeW-1:0];
  assign is_sym    = !child[htld_pkg::CodeW-1];
  assign emit      = is_sym && (child[htld_pkg::SymW-1:0] != htld_pkg::SymCr);
  assign out_free  = !out_valid_q || out_ready_i;
  assign final_bit = (bit_q == 3'd7);
  assign step_ok   = (state_q == htld_pkg::StWalk) && (!emit || !pend_valid_q || out_free);
  assign flush_ok  = (state_q == htld_pkg::StFlush) && (!pend_valid_q || out_free);
  assign next_walk = is_sym ? root_q : child;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      htld_pkg::StIdle: begin
        if (accept && (req_type_i == htld_pkg::ReqData)) begin
          state_d = htld_pkg::StWalk;
        end
      end
      htld_pkg::StWalk: begin
        if (step_ok && final_bit) begin
          state_d = htld_pkg::StFlush;
        end
      end
      htld_pkg::StFlush: begin
        if (flush_ok) begin
          state_d = htld_pkg::StIdle;
        end
      end
      default: state_d = htld_pkg::StIdle;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    in_ready_o   = (state_q == htld_pkg::StIdle);
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = walk_q[htld_pkg::NodeW-1:0];
    walk_d       = walk_q;
    skip_d       = skip_q;
    byte_d       = byte_q;
    bit_d        = bit_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    pend_eol_d   = pend_eol_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_sym_d    = out_sym_q;
    out_eol_d    = out_eol_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      htld_pkg::StIdle: begin
        if (accept) begin
          case (req_type_i)
            htld_pkg::ReqLoad: begin
              wr_en = 1'b1;
            end
            htld_pkg::ReqData: begin
              rd_en  = 1'b1;
              byte_d = data_byte_i;
              bit_d  = skip_q;
              skip_d = '0;
            end
            htld_pkg::ReqRestart: begin
              walk_d = root_q;
              skip_d = skip_bits_i[3] ? 3'd0 : skip_bits_i[2:0];
            end
            default: ;
          endcase
        end
      end
      htld_pkg::StWalk: begin
        if (step_ok) begin
          walk_d = next_walk;
          if (!final_bit) begin
            rd_en   = 1'b1;
            rd_addr = next_walk[htld_pkg::NodeW-1:0];
            bit_d   = bit_q + 3'd1;
          end
          if (emit) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_sym_d   = pend_sym_q;
              out_eol_d   = pend_eol_q;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_sym_d   = child[htld_pkg::SymW-1:0];
            pend_eol_d   = (child[htld_pkg::SymW-1:0] == htld_pkg::SymLf);
          end
        end
      end
      htld_pkg::StFlush: begin
        if (flush_ok && pend_valid_q) begin
          out_valid_d  = 1'b1;
          out_sym_d    = pend_sym_q;
          out_eol_d    = pend_eol_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign symbol_o      = out_sym_q;
  assign end_of_line_o = out_eol_q;
  assign last_o        = out_last_q;

  // Node table with one write and one registered read per cycle. Writes and
  // walk reads never fall in the same cycle, so no forwarding is required.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[node_index_i] <= {left_child_i, right_child_i};
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= htld_pkg::StIdle;
      root_q       <= htld_pkg::RootReset;
      walk_q       <= htld_pkg::RootReset;
      skip_q       <= '0;
      bit_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      walk_q       <= walk_d;
      skip_q       <= skip_d;
      bit_q        <= bit_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    pend_sym_q <= pend_sym_d;
    pend_eol_q <= pend_eol_d;
    out_sym_q  <= out_sym_d;
    out_eol_q  <= out_eol_d;
    out_last_q <= out_last_d;
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for huffman_tree_line_decoder: loads node tables, streams
// data bytes and restarts, and checks every decoded symbol against its own tree walker.
// Depends on htld_pkg and the decoder RTL; it reads no files.
module tb;

  // The request code that the package leaves unnamed; the block must ignore it.
  localparam logic [1:0]  ReqUnused    = 2'd3;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned PhaseWords   = 82;
  localparam int unsigned RecentDepth  = 6;

  // One input word, with every field of the request present.
  typedef struct packed {
    logic [1:0]                 req;
    logic [htld_pkg::NodeW-1:0] node;
    logic [htld_pkg::CodeW-1:0] left_code;
    logic [htld_pkg::CodeW-1:0] right_code;
    logic [7:0]                 data;
    logic [3:0]                 skip;
  } word_t;

  // One decoded symbol as it should leave the block.
  typedef struct packed {
    logic [htld_pkg::SymW-1:0] symbol;
    logic                      eol;
    logic                      last;
  } symbol_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       in_valid_i    = 1'b0;
  logic                       in_ready_o;
  logic [1:0]                 req_type_i    = '0;
  logic [htld_pkg::NodeW-1:0] node_index_i  = '0;
  logic [htld_pkg::CodeW-1:0] left_child_i  = '0;
  logic [htld_pkg::CodeW-1:0] right_child_i = '0;
  logic [7:0]                 data_byte_i   = '0;
  logic [3:0]                 skip_bits_i   = '0;
  logic                       cfg_we_i      = 1'b0;
  logic [htld_pkg::CodeW-1:0] cfg_wdata_i   = '0;
  logic                       out_valid_o;
  logic                       out_ready_i   = 1'b0;
  logic [htld_pkg::SymW-1:0]  symbol_o;
  logic                       end_of_line_o;
  logic                       last_o;

  huffman_tree_line_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .node_index_i  (node_index_i),
    .left_child_i  (left_child_i),
    .right_child_i (right_child_i),
    .data_byte_i   (data_byte_i),
    .skip_bits_i   (skip_bits_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .symbol_o      (symbol_o),
    .end_of_line_o (end_of_line_o),
    .last_o        (last_o)
  );

  // Our own copy of the decoder state, advanced on every accepted word. Table
  // entries start unknown, which is harmless because the stimulus never walks
  // into a node that has not been loaded.
  logic [htld_pkg::CodeW-1:0] tree_left  [256];
  logic [htld_pkg::CodeW-1:0] tree_right [256];
  logic [htld_pkg::CodeW-1:0] root_code    = htld_pkg::RootReset;
  logic [htld_pkg::CodeW-1:0] walk_code    = htld_pkg::RootReset;
  logic [3:0]                 skip_pending = '0;

  symbol_t expected_symbols [$];
  word_t   pending_words    [$];
  word_t   offered;

  // Planning state. Every node listed in recent_nodes has been loaded, and a
  // child pointer is only ever aimed at such a node, so a walk that starts on a
  // loaded node can never reach an unloaded one.
  logic [htld_pkg::NodeW-1:0] recent_nodes [$];
  logic [htld_pkg::CodeW-1:0] plan_root = htld_pkg::RootReset;
  int unsigned                planned   = 0;

  int unsigned fault_count    = 0;
  int unsigned words_taken    = 0;
  int unsigned symbols_taken  = 0;
  int unsigned root_writes    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned holds_served   = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= 30) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // Tree walker: applies one accepted word to the predicted state and queues
  // whatever symbols that word should produce, in order.
  task automatic walk_tree(input word_t w);
    symbol_t                    found [$];
    logic [htld_pkg::CodeW-1:0] next_code;
    int unsigned                first_bit;
    case (w.req)
      htld_pkg::ReqLoad: begin
        tree_left[w.node]  = w.left_code;
        tree_right[w.node] = w.right_code;
      end
      htld_pkg::ReqRestart: begin
        // A skip of eight or more leaves the next byte whole.
        skip_pending = (w.skip >= 4'd8) ? 4'd0 : w.skip;
        walk_code    = root_code;
      end
      htld_pkg::ReqData: begin
        first_bit    = 32'(skip_pending);
        skip_pending = '0;
        for (int b = first_bit; b < 8; b++) begin
          // Bit 8 of the walk position plays no part in addressing the table,
          // which is what makes a root code below 256 usable.
          next_code = w.data[7-b] ? tree_left[walk_code[htld_pkg::NodeW-1:0]]
                                  : tree_right[walk_code[htld_pkg::NodeW-1:0]];
          if (next_code[htld_pkg::CodeW-1]) begin
            walk_code = next_code;
          end else begin
            walk_code = root_code;
            // Carriage returns vanish; newline carries the end-of-line flag.
            if (next_code[htld_pkg::SymW-1:0] != htld_pkg::SymCr) begin
              found.push_back('{symbol: next_code[htld_pkg::SymW-1:0],
                                eol:    (next_code[htld_pkg::SymW-1:0] == htld_pkg::SymLf),
                                last:   1'b0});
            end
          end
        end
        // The last flag sits on the final symbol actually emitted for the byte.
        if (found.size() > 0) begin
          found[found.size()-1].last = 1'b1;
        end
        foreach (found[i]) begin
          expected_symbols.push_back(found[i]);
        end
      end
      default: ;
    endcase
  endtask

  // Fields that a request does not use are still filled at random, so every
  // port bit toggles and the block is seen to ignore them.
  function automatic word_t blank_word(input logic [1:0] req);
    word_t w;
    w.req        = req;
    w.node       = 8'($urandom);
    w.left_code  = 9'($urandom);
    w.right_code = 9'($urandom);
    w.data       = 8'($urandom);
    w.skip       = 4'($urandom_range(8));
    return w;
  endfunction

  task automatic plan_load(input logic [htld_pkg::NodeW-1:0] idx,
                           input logic [htld_pkg::CodeW-1:0] left_code,
                           input logic [htld_pkg::CodeW-1:0] right_code);
    word_t w;
    w            = blank_word(htld_pkg::ReqLoad);
    w.node       = idx;
    w.left_code  = left_code;
    w.right_code = right_code;
    pending_words.push_back(w);
    recent_nodes.push_back(idx);
    if (recent_nodes.size() > RecentDepth) begin
      void'(recent_nodes.pop_front());
    end
    planned++;
  endtask

  task automatic plan_data(input logic [7:0] data);
    word_t w;
    w      = blank_word(htld_pkg::ReqData);
    w.data = data;
    pending_words.push_back(w);
    planned++;
  endtask

  task automatic plan_restart(input logic [3:0] skip);
    word_t w;
    w      = blank_word(htld_pkg::ReqRestart);
    w.skip = skip;
    pending_words.push_back(w);
    planned++;
  endtask

  // A child is a pointer to a recently loaded node, a newline, a carriage
  // return or any other symbol. Favouring recent nodes builds deeper trees.
  function automatic logic [htld_pkg::CodeW-1:0] pick_child();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40 && recent_nodes.size() > 0) begin
      return {1'b1, recent_nodes[$urandom_range(recent_nodes.size() - 1)]};
    end
    if (roll < 52) begin
      return {1'b0, htld_pkg::SymLf};
    end
    if (roll < 60) begin
      return {1'b0, htld_pkg::SymCr};
    end
    return {1'b0, 8'($urandom)};
  endfunction

  // Well-formed sequences in about a third of bursts: a few fresh nodes, the root
  // node re-pointed into them, a restart and then a run of bytes. The rest is a
  // loose mix of bytes, stray loads, restarts and unused requests.
  task automatic plan_burst();
    logic [htld_pkg::NodeW-1:0] idx;
    int unsigned                roll;
    if ($urandom_range(99) < 35) begin
      repeat ($urandom_range(1, 5)) begin
        idx = 8'($urandom);
        plan_load(idx, pick_child(), pick_child());
      end
      plan_load(plan_root[htld_pkg::NodeW-1:0], pick_child(), pick_child());
      plan_restart(4'($urandom_range(8)));
      repeat ($urandom_range(3, 10)) begin
        plan_data(8'($urandom));
      end
    end else begin
      repeat ($urandom_range(2, 8)) begin
        roll = $urandom_range(99);
        if (roll < 70) begin
          plan_data(8'($urandom));
        end else if (roll < 82) begin
          idx = 8'($urandom);
          plan_load(idx, pick_child(), pick_child());
        end else if (roll < 94) begin
          plan_restart(4'($urandom_range(8)));
        end else begin
          pending_words.push_back(blank_word(ReqUnused));
        end
      end
    end
  endtask

  task automatic plan_phase();
    planned = 0;
    while (planned < PhaseWords) begin
      plan_burst();
    end
  endtask

  // Waits for every planned word to be taken and every symbol to arrive, then
  // gives a byte with no output time to finish before anything else happens.
  task automatic settle();
    while (pending_words.size() > 0 || in_valid_i || expected_symbols.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_root(input logic [htld_pkg::CodeW-1:0] code);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    root_code   = code;
    plan_root   = code;
    root_writes++;
  endtask

  // Sender: offers the next pending word, sometimes holding back.
  // A word already offered stays on the port until the block takes it.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        walk_tree(offered);
        words_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered       = pending_words.pop_front();
          in_valid_i    <= 1'b1;
          req_type_i    <= offered.req;
          node_index_i  <= offered.node;
          left_child_i  <= offered.left_code;
          right_child_i <= offered.right_code;
          data_byte_i   <= offered.data;
          skip_bits_i   <= offered.skip;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each symbol taken against the oldest prediction, and
  // decides its readiness for the next cycle. A requested hold-off keeps ready
  // low for a long stretch so that the block backs up onto its input.
  always @(posedge clk_i) begin : receiver
    symbol_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        symbols_taken++;
        if (expected_symbols.size() == 0) begin
          report_fault($sformatf("symbol %0d arrived with nothing expected", symbol_o));
        end else begin
          want = expected_symbols.pop_front();
          if (symbol_o !== want.symbol) begin
            report_fault($sformatf("symbol %0d: symbol_o %0d, want %0d",
                                   symbols_taken, symbol_o, want.symbol));
          end
          if (end_of_line_o !== want.eol) begin
            report_fault($sformatf("symbol %0d: end_of_line_o %0b, want %0b",
                                   symbols_taken, end_of_line_o, want.eol));
          end
          if (last_o !== want.last) begin
            report_fault($sformatf("symbol %0d: last_o %0b, want %0b",
                                   symbols_taken, last_o, want.last));
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left   = HoldCycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: any cycle in which a word moves on either side resets the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("No word moved for %0d cycles; %0d words unsent, %0d symbols outstanding",
               quiet_cycles, pending_words.size(), expected_symbols.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [htld_pkg::NodeW-1:0] pick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Root left at its reset value; the sender idles less than the receiver.
    send_idle_pct  = 24;
    recv_stall_pct = 49;

    // A small fixed tree. Node 0 is the reset root: a 1 goes to node 1 and a 0
    // to node 255. Node 1 gives newline on a 1 and node 2 on a 0; node 2 gives
    // 'A' on a 1 and a carriage return on a 0; node 255 gives symbols 255 and 0.
    // Leaves go in first so that no pointer ever names an unloaded node.
    plan_load(8'd2, {1'b0, 8'd65}, {1'b0, htld_pkg::SymCr});
    plan_load(8'd1, {1'b0, htld_pkg::SymLf}, 9'd258);
    plan_load(8'd255, 9'd255, 9'd0);
    plan_load(8'd0, 9'd257, 9'd511);
    plan_data(8'h00);               // four zero symbols
    plan_data(8'hFF);               // four newlines
    plan_data(8'h92);               // two dropped returns, walk left inside node 2
    plan_data(8'hC0);               // finishes 'A' across the byte boundary
    plan_restart(4'd3);
    plan_data(8'hFF);               // first three bits discarded
    plan_restart(4'd8);
    plan_data(8'h55);               // a large skip leaves the byte whole
    plan_restart(4'd7);
    plan_data(8'h80);               // one bit used, no symbol, walk carried on
    plan_data(8'h7F);               // the skip applied to one byte only
    plan_restart(4'd0);
    plan_data(8'h3C);
    pending_words.push_back(blank_word(ReqUnused));
    plan_data(8'hA5);
    plan_load(8'd128, 9'd511, 9'd256);
    plan_data(8'h6D);
    plan_phase();
    settle();

    // Highest root code, which starts every walk at node 255.
    write_root(9'd511);
    plan_phase();
    settle();

    // Roles swapped, and a root code below 256 on a loaded node.
    send_idle_pct  = 49;
    recv_stall_pct = 24;
    pick = recent_nodes[$urandom_range(recent_nodes.size() - 1)];
    write_root({1'b0, pick});
    plan_phase();
    settle();

    // No idling; the reset root written back, with a long output hold-off
    // while the sender keeps offering words.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_root(htld_pkg::RootReset);
    plan_phase();
    hold_requests++;
    settle();

    pick = recent_nodes[$urandom_range(recent_nodes.size() - 1)];
    write_root({1'b1, pick});
    plan_phase();
    settle();

    $display("Covered %0d words over %0d root settings, %0d symbols checked.",
             words_taken, root_writes + 1, symbols_taken);
    $display("Both sides idled in turn, then ran flat out through a %0d-cycle hold-off.",
             HoldCycles);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
